FILE: sv/sddbr_pkg.sv
// Package: widths and constants of the dead-block replacement policy.
package sddbr_pkg;
  localparam int SETS_DEF = 2048;
  localparam int WAYS_DEF = 16;
  localparam int LEADER_DEF = 32;
  localparam int SIG_BITS_DEF = 6;
  localparam int SET_W = 11;
  localparam int WAY_W = 4;
  localparam int ADDR_W = 64;
  localparam int PERIOD_W = 21;
  localparam int COUNT_W = 20;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 21'd16384;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 21'd1048576;
  localparam logic [ADDR_W-1:0] LINE_STEP = 64'd64;
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_UPDATE = 1'b1;
endpackage

FILE: sv/sddbr_if.sv
// Interfaces: request channel, result channel and register write channel.
interface sddbr_req_if;
  logic valid;
  logic ready;
  logic operation;
  logic [10:0] set_index;
  logic [3:0] way;
  logic [63:0] address;
  logic [63:0] pc;
  logic hit;
  modport source (output valid, operation, set_index, way, address, pc, hit, input ready);
  modport sink (input valid, operation, set_index, way, address, pc, hit, output ready);
endinterface

interface sddbr_rsp_if;
  logic valid;
  logic ready;
  logic [3:0] victim_way;
  modport source (output valid, victim_way, input ready);
  modport sink (input valid, victim_way, output ready);
endinterface

interface sddbr_cfg_if;
  logic valid;
  logic ready;
  logic [20:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/sddbr_ram.sv
// Generic single-port synchronous RAM with registered read.
module sddbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: sv/ship_dip_dead_block_replacement.sv
// Top level: dead-block replacement policy with set-row memories and a sequencer.
// A query reads its set row at the accept edge, then passes two compare stages whose
// results are registered before its victim is offered; an update writes its set back
// from the work state. A request is taken only when idle, once the last is done; a
// stalled result holds off the next request. Reset: synchronous; a clearing pass zeroes
// the set memories, during which no request is taken. Reuse counters reset to one.
module ship_dip_dead_block_replacement
  import sddbr_pkg::*;
#(
  parameter int SETS = SETS_DEF,
  parameter int WAYS = WAYS_DEF,
  parameter int LEADER_SETS = LEADER_DEF,
  parameter int SIGNATURE_BITS = SIG_BITS_DEF
) (
  input logic clk,
  input logic rst,
  sddbr_req_if.sink req,
  sddbr_rsp_if.source rsp,
  sddbr_cfg_if.sink cfg
);
  localparam int SA_W = $clog2(SETS);
  localparam int WI_W = $clog2(WAYS);
  localparam int SIG_N = 1 << SIGNATURE_BITS;
  // one way entry: dead mark, signature, block address
  localparam int ENT_W = 1 + SIGNATURE_BITS + ADDR_W;
  localparam int ROW_W = ENT_W * WAYS;
  localparam int SROW_W = 1 + ADDR_W;
  // victim search: first dead way, else lowest address per group of four, then overall
  localparam int GROUPS = (WAYS + 3) / 4;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WORK  = 5'b00100,
    S_PICK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic [SA_W-1:0] clr_addr;
  logic [PERIOD_W-1:0] period;
  logic [COUNT_W-1:0] update_count;
  logic [1:0] reuse [SIG_N];

  // held request
  logic op;
  logic [SET_W-1:0] set_q;
  logic [WAY_W-1:0] way_q;
  logic [ADDR_W-1:0] addr_q, pc_q;
  logic hit_q, in_range;
  logic [WAY_W-1:0] victim;
  logic out_valid;

  // memories: way rows and set rows share one address
  logic row_we;
  logic [SA_W-1:0] mem_addr;
  logic [ROW_W-1:0] row_rd, row_wd;
  logic [SROW_W-1:0] srow_rd, srow_wd;

  sddbr_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rows (
    .clk(clk), .we(row_we), .addr(mem_addr), .wdata(row_wd), .rdata(row_rd));
  sddbr_ram #(.WIDTH(SROW_W), .DEPTH(SETS)) u_srows (
    .clk(clk), .we(row_we), .addr(mem_addr), .wdata(srow_wd), .rdata(srow_rd));

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.victim_way = victim;

  // effective period: zero acts as one, large values clamp
  logic [PERIOD_W-1:0] eff_period;
  always_comb begin
    if (period == '0) begin
      eff_period = PERIOD_W'(1);
    end else if (period > PERIOD_MAX) begin
      eff_period = PERIOD_MAX;
    end else begin
      eff_period = period;
    end
  end

  // derived update terms
  logic [ADDR_W-1:0] prev_addr, d_up, d_dn;
  logic streaming_new, bypass, sig_strong, bip_leader, decay;
  logic [SIGNATURE_BITS-1:0] sig, old_sig;
  logic [ENT_W-1:0] old_ent;
  logic [1:0] sig_cnt;
  logic dead_new;
  logic [ADDR_W-1:0] pxa;
  logic [COUNT_W:0] cnt_inc;

  always_comb begin
    prev_addr = srow_rd[ADDR_W-1:0];
    d_up = addr_q - prev_addr;
    d_dn = prev_addr - addr_q;
    if (d_up == LINE_STEP || d_dn == LINE_STEP) begin
      streaming_new = 1'b1;
    end else if (addr_q != prev_addr) begin
      streaming_new = 1'b0;
    end else begin
      streaming_new = srow_rd[ADDR_W];
    end
    sig = SIGNATURE_BITS'(pc_q ^ (addr_q >> 6));
    old_ent = row_rd[way_q[WI_W-1:0]*ENT_W +: ENT_W];
    old_sig = old_ent[ADDR_W +: SIGNATURE_BITS];
    pxa = pc_q ^ addr_q;
    cnt_inc = {1'b0, update_count} + 1'b1;
    decay = ({1'b0, cnt_inc} >= {1'b0, eff_period});
    // counter of sig after training and decay
    sig_cnt = reuse[sig];
    if (hit_q) begin
      if (sig_cnt != 2'd3) sig_cnt = sig_cnt + 2'd1;
    end else if (old_sig == sig && sig_cnt != 2'd0) begin
      sig_cnt = sig_cnt - 2'd1;
    end
    if (decay && sig_cnt != 2'd0) sig_cnt = sig_cnt - 2'd1;
    bypass = streaming_new && (pxa[1:0] != 2'd0);
    sig_strong = sig_cnt >= 2'd2;
    bip_leader = (32'(set_q) >= LEADER_SETS) && (LEADER_SETS <= SETS) &&
                 (32'(set_q) >= SETS - LEADER_SETS);
    if (bypass && !hit_q) begin
      dead_new = 1'b1;
    end else if (sig_strong) begin
      dead_new = 1'b0;
    end else if (!bip_leader) begin
      dead_new = 1'b1;
    end else begin
      dead_new = (pxa[4:0] != 5'd0);
    end
  end

  // victim search, first stage: first dead way and lowest address per group
  logic dead_any, dead_any_q;
  logic [WAY_W-1:0] dead_way, dead_way_q;
  logic [ADDR_W-1:0] grp_low [GROUPS];
  logic [WAY_W-1:0] grp_way [GROUPS];
  logic [ADDR_W-1:0] grp_low_q [GROUPS];
  logic [WAY_W-1:0] grp_way_q [GROUPS];
  always_comb begin
    dead_any = 1'b0;
    dead_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd[w*ENT_W + ENT_W - 1]) begin
        dead_any = 1'b1;
        dead_way = WAY_W'(w);
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_low[g] = row_rd[4*g*ENT_W +: ADDR_W];
      grp_way[g] = WAY_W'(4*g);
      for (int k = 1; k < 4; k++) begin
        // strict compare keeps the lower way on a tie
        if (4*g + k < WAYS && row_rd[(4*g+k)*ENT_W +: ADDR_W] < grp_low[g]) begin
          grp_low[g] = row_rd[(4*g+k)*ENT_W +: ADDR_W];
          grp_way[g] = WAY_W'(4*g + k);
        end
      end
    end
  end

  // victim search, second stage: lowest address across the held group results
  logic [ADDR_W-1:0] fin_low;
  logic [WAY_W-1:0] fin_way;
  always_comb begin
    fin_low = grp_low_q[0];
    fin_way = grp_way_q[0];
    for (int g = 1; g < GROUPS; g++) begin
      if (grp_low_q[g] < fin_low) begin
        fin_low = grp_low_q[g];
        fin_way = grp_way_q[g];
      end
    end
  end

  // memory port control; while idle the address follows the request port so
  // the set row is back in the cycle after acceptance
  always_comb begin
    row_we = 1'b0;
    mem_addr = SA_W'(set_q);
    row_wd = row_rd;
    srow_wd = {streaming_new, addr_q};
    if (state == S_CLEAR) begin
      row_we = 1'b1;
      mem_addr = clr_addr;
      row_wd = '0;
      srow_wd = '0;
    end else if (state == S_IDLE) begin
      mem_addr = SA_W'(req.set_index);
    end else if (state == S_WORK && op == OP_UPDATE && in_range) begin
      row_we = 1'b1;
      row_wd[way_q[WI_W-1:0]*ENT_W +: ENT_W] = {dead_new, sig, addr_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      period <= PERIOD_RESET;
      update_count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SIG_N; i++) reuse[i] <= 2'd1;
    end else begin
      if (cfg.valid) begin
        period <= cfg.data;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == SETS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            op <= req.operation;
            set_q <= req.set_index;
            way_q <= req.way;
            addr_q <= req.address;
            pc_q <= req.pc;
            hit_q <= req.hit;
            in_range <= (32'(req.set_index) < SETS) &&
                        (req.operation == OP_QUERY || 32'(req.way) < WAYS);
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (op == OP_QUERY) begin
            // hold the first-stage search results for the final pick
            dead_any_q <= dead_any;
            dead_way_q <= dead_way;
            for (int g = 0; g < GROUPS; g++) begin
              grp_low_q[g] <= grp_low[g];
              grp_way_q[g] <= grp_way[g];
            end
            state <= S_PICK;
          end else begin
            if (in_range) begin
              for (int i = 0; i < SIG_N; i++) begin
                logic [1:0] c;
                c = reuse[i];
                if (hit_q && SIGNATURE_BITS'(i) == sig && c != 2'd3) c = c + 2'd1;
                if (!hit_q && SIGNATURE_BITS'(i) == old_sig && c != 2'd0) c = c - 2'd1;
                if (decay && c != 2'd0) c = c - 2'd1;
                reuse[i] <= c;
              end
              update_count <= decay ? '0 : cnt_inc[COUNT_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        S_PICK: begin
          if (!in_range) begin
            victim <= '0;
          end else if (dead_any_q) begin
            victim <= dead_way_q;
          end else begin
            victim <= fin_way;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
